// ===== sv/laser_profile_gap_fill_assert.svh =====
// ----------------------------------------------------------------------------
// laser profile gap fill assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef LASER_PROFILE_GAP_FILL_ASSERT_SVH
`define LASER_PROFILE_GAP_FILL_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPGF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpgf assertion failed");
`define LPGF_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lpgf forbidden condition seen");
`else
`define LPGF_ASSERT(label, clk, rst_n, prop)
`define LPGF_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== sv/lpgf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgf_pkg
// field widths, request codes and controller states for the profile block
// ----------------------------------------------------------------------------
package lpgf_pkg;

    localparam int REQ_W  = 1;
    localparam int VIEW_W = 6;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 12;
    localparam int RED_W  = 8;
    localparam int NV_W   = 7;

    localparam logic [NV_W-1:0] NV_RESET = 7'd64;

    localparam logic [REQ_W-1:0] REQ_PIXEL    = 1'b0;
    localparam logic [REQ_W-1:0] REQ_ROW_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_SUM_END,
        S_DIV,
        S_DIV_WAIT,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

endpackage

// ===== sv/laser_profile_gap_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_profile_gap_fill
// per view and row laser column store with cross-view gap filling on row read
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------
//   in      | sink      | i_in_valid / o_in_stall   | req_type view row column red
//   out     | source    | o_out_valid / i_out_stall | view row line_column filled last
//   cfg     | sink      | i_cfg_wr_en               | num_views
//
// pixel transfers: one per cycle while idle, read-modify-write on the store with forwarding
// row read: a summing pass over the views, the divider when filling, then a
// read state and an emit state per view to read, emit and clear each entry
// after reset the store is cleared one entry a cycle, all 2**(clog2(MAX_VIEWS) +
// clog2(MAX_ROWS)) entries (65536 by default), no input transfer during that pass
// input stalls for the whole row read; a stalled output holds the emit sequence
// ----------------------------------------------------------------------------
`include "laser_profile_gap_fill_assert.svh"

module laser_profile_gap_fill
    import lpgf_pkg::*;
#(
    parameter int MAX_VIEWS   = 64,
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [NV_W-1:0]   i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [VIEW_W-1:0] i_view,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_column,
    input  logic [RED_W-1:0]  i_red_level,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VIEW_W-1:0] o_out_view,
    output logic [ROW_W-1:0]  o_out_row,
    output logic [COL_W-1:0]  o_line_column,
    output logic              o_was_filled,
    output logic              o_last
);

    localparam int VIW   = $clog2(MAX_VIEWS);
    localparam int NVW   = $clog2(MAX_VIEWS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = VIW + RW;
    localparam int DEPTH = 2 ** AW;
    localparam int SUM_W = COL_W + VIW;

    t_state r_state;
    t_state n_state;

    logic [NV_W-1:0]   r_num_views;
    logic [NVW-1:0]    w_nv;

    logic [COL_W-1:0]  r_store [DEPTH];
    logic [COL_W-1:0]  r_mem_q;
    logic [AW-1:0]     w_rd_addr;
    logic              w_we;
    logic [AW-1:0]     w_wr_addr;
    logic [COL_W-1:0]  w_wr_data;
    logic [AW-1:0]     r_clr_addr;

    logic              r_px_v;
    logic [AW-1:0]     r_px_addr;
    logic [COL_W-1:0]  r_px_col;
    logic              r_fwd_v;
    logic [AW-1:0]     r_fwd_addr;
    logic [COL_W-1:0]  r_fwd_data;
    logic [AW-1:0]     w_px_addr;
    logic              w_px_hit;
    logic [COL_W-1:0]  w_px_old;
    logic              w_px_wr;

    logic [ROW_W-1:0]  r_rd_row;
    logic              r_row_ok;
    logic [VIW-1:0]    r_vcnt;
    logic              r_acc_pend;
    logic [SUM_W-1:0]  r_sum;
    logic [NVW-1:0]    r_found;
    logic [COL_W-1:0]  w_rd_data;
    logic              w_vlast;
    logic              w_fill;

    logic              w_px_go;
    logic              w_rr_go;
    logic              w_sum_rd;
    logic              w_emit_ld;
    logic              w_div_start;
    logic              w_div_done;
    logic [SUM_W-1:0]  w_quot;

    logic              r_o_valid;
    logic [VIEW_W-1:0] r_o_view;
    logic [ROW_W-1:0]  r_o_row;
    logic [COL_W-1:0]  r_o_col;
    logic              r_o_filled;
    logic              r_o_last;

    // effective view count
    always_comb begin
        if (r_num_views == '0) begin
            w_nv = NVW'(1);
        end else if (32'(r_num_views) > MAX_VIEWS) begin
            w_nv = NVW'(MAX_VIEWS);
        end else begin
            w_nv = NVW'(r_num_views);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_views <= NV_RESET;
        end else if (i_cfg_wr_en) begin
            r_num_views <= i_cfg_wr_data;
        end
    end

    assign w_vlast   = NVW'(r_vcnt) == (w_nv - NVW'(1));
    assign w_fill    = (r_found != '0) && (r_found < w_nv);
    assign w_rd_data = r_row_ok ? r_mem_q : '0;
    assign w_px_addr = {VIW'(i_view), RW'(i_row)};

    // controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_px_go     = 1'b0;
        w_rr_go     = 1'b0;
        w_sum_rd    = 1'b0;
        w_emit_ld   = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_PIXEL) begin
                        w_px_go = 1'b1;
                    end else begin
                        w_rr_go = 1'b1;
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                w_sum_rd = 1'b1;
                if (w_vlast) begin
                    n_state = S_SUM_END;
                end
            end
            S_SUM_END: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_fill) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV_WAIT;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_state = S_EMIT_WR;
                end
            end
            S_EMIT_WR: begin
                w_emit_ld = 1'b1;
                n_state   = w_vlast ? S_IDLE : S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

    // store ports
    always_comb begin
        if (r_state == S_IDLE) begin
            w_rd_addr = w_px_addr;
        end else begin
            w_rd_addr = {r_vcnt, RW'(r_rd_row)};
        end
    end

    assign w_px_hit = r_fwd_v && (r_fwd_addr == r_px_addr);
    assign w_px_old = w_px_hit ? r_fwd_data : r_mem_q;
    assign w_px_wr  = r_px_v && (r_px_col > w_px_old);

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_px_addr;
        w_wr_data = r_px_col;
        if (r_state == S_CLEAR) begin
            w_we      = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else if (w_px_wr) begin
            w_we = 1'b1;
        end else if (w_emit_ld && r_row_ok) begin
            w_we      = 1'b1;
            w_wr_addr = {r_vcnt, RW'(r_rd_row)};
            w_wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_wr_addr] <= w_wr_data;
        end
        r_mem_q <= r_store[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // pixel read-modify-write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_v  <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            r_px_v  <= w_px_go && (i_red_level != '0) && (32'(i_view) < 32'(w_nv)) &&
                       (32'(i_row) < MAX_ROWS) && (32'(i_column) < MAX_COLUMNS);
            r_fwd_v <= w_px_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px_addr  <= w_px_addr;
        r_px_col   <= i_column;
        r_fwd_addr <= r_px_addr;
        r_fwd_data <= r_px_col;
    end

    // row read: sum pass, mean, emit pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt     <= '0;
            r_acc_pend <= 1'b0;
            r_found    <= '0;
        end else begin
            r_acc_pend <= w_sum_rd;
            if (w_rr_go) begin
                r_vcnt  <= '0;
                r_found <= '0;
            end else if (w_sum_rd) begin
                r_vcnt <= w_vlast ? '0 : r_vcnt + VIW'(1);
            end else if (w_emit_ld && !w_vlast) begin
                r_vcnt <= r_vcnt + VIW'(1);
            end
            if (r_acc_pend && (w_rd_data != '0)) begin
                r_found <= r_found + NVW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rr_go) begin
            r_sum    <= '0;
            r_rd_row <= i_row;
            r_row_ok <= 32'(i_row) < MAX_ROWS;
        end else if (r_acc_pend) begin
            r_sum <= r_sum + SUM_W'(w_rd_data);
        end
    end

    lpgf_div #(
        .NUM_W (SUM_W),
        .DEN_W (NVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_sum),
        .i_den   (r_found),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit_ld) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_ld) begin
            r_o_view <= VIEW_W'(r_vcnt);
            r_o_row  <= r_rd_row;
            r_o_last <= w_vlast;
            if (w_fill && (w_rd_data == '0)) begin
                r_o_col    <= w_quot[COL_W-1:0];
                r_o_filled <= 1'b1;
            end else begin
                r_o_col    <= w_rd_data;
                r_o_filled <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_view    = r_o_view;
    assign o_out_row     = r_o_row;
    assign o_line_column = r_o_col;
    assign o_was_filled  = r_o_filled;
    assign o_last        = r_o_last;

    // checks
    `LPGF_ASSERT(a_no_overwrite, i_clk, i_rst_n, w_emit_ld |-> !r_o_valid)
    `LPGF_ASSERT(a_px_slot, i_clk, i_rst_n, r_px_v |-> (r_state == S_IDLE || r_state == S_SUM))
    `LPGF_ASSERT(a_load_src, i_clk, i_rst_n, $rose(r_o_valid) |-> $past(r_state == S_EMIT_WR))
    `LPGF_ASSERT_NEVER(a_div_zero, i_clk, i_rst_n, w_div_start && (r_found == '0))

endmodule

// ===== sv/lpgf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lpgf_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_shift;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    assign w_shift = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== dv/tb_laser_profile_gap_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laser_profile_gap_fill
// drives pixel and row read transfers into the profile block, keeps its own
// per view and row column store to predict row reads, and compares each
// output transfer field by field; a directed table comes first, then random
// phases over several view counts and idling patterns
// ----------------------------------------------------------------------------
module tb_laser_profile_gap_fill;
    import lpgf_pkg::*;

    localparam int N_VIEWS       = 64;
    localparam int N_ROWS        = 1024;
    localparam int N_COLS        = 4096;
    localparam int IDLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 50;
    localparam int PHASE_ITEMS   = 40;

    typedef enum logic [1:0] {
        ACT_PIXEL,
        ACT_READ,
        ACT_CFG
    } t_action;

    typedef struct {
        t_action           act;
        logic [VIEW_W-1:0] view;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [RED_W-1:0]  red;
        bit                typed;
        logic [COL_W-1:0]  typed_col;
        bit                typed_fill;
        logic [VIEW_W-1:0] typed_src;
    } t_scan_row;

    typedef struct {
        logic [VIEW_W-1:0] view;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              filled;
        logic              last;
    } t_profile_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [NV_W-1:0]   i_cfg_wr_data = '0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [REQ_W-1:0]  i_req_type    = REQ_PIXEL;
    logic [VIEW_W-1:0] i_view        = '0;
    logic [ROW_W-1:0]  i_row         = '0;
    logic [COL_W-1:0]  i_column      = '0;
    logic [RED_W-1:0]  i_red_level   = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [VIEW_W-1:0] o_out_view;
    logic [ROW_W-1:0]  o_out_row;
    logic [COL_W-1:0]  o_line_column;
    logic              o_was_filled;
    logic              o_last;

    logic [COL_W-1:0] column_store [N_VIEWS*N_ROWS];
    logic [NV_W-1:0]  views_reg;
    t_profile_result  expected_profile [$];
    t_scan_row        scan_table [$];
    int               mismatches  = 0;
    int               idle_cycles = 0;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;

    always #5 i_clk = ~i_clk;

    laser_profile_gap_fill u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_view        (i_view),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_red_level   (i_red_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_view    (o_out_view),
        .o_out_row     (o_out_row),
        .o_line_column (o_line_column),
        .o_was_filled  (o_was_filled),
        .o_last        (o_last)
    );

    function automatic int active_views();
        if (views_reg == 0) return 1;
        if (views_reg > N_VIEWS) return N_VIEWS;
        return int'(views_reg);
    endfunction

    function automatic void record_pixel(input logic [VIEW_W-1:0] view,
                                         input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] column,
                                         input logic [RED_W-1:0] red);
        int idx;
        if (red != 0 && view < active_views() && row < N_ROWS && column < N_COLS) begin
            idx = int'(view) * N_ROWS + int'(row);
            if (column > column_store[idx]) column_store[idx] = column;
        end
    endfunction

    function automatic void queue_expected(input t_profile_result r);
        expected_profile.insert(expected_profile.size(), r);
    endfunction

    // gap filling over all views in use, then the row is cleared
    function automatic void read_profile_row(input logic [ROW_W-1:0] row, input bit queue_it);
        int              nv;
        int              found;
        int              sum;
        int              mean;
        int              idx;
        int              v;
        bit              fill;
        bit              row_ok;
        t_profile_result r;
        nv     = active_views();
        found  = 0;
        sum    = 0;
        mean   = 0;
        row_ok = row < N_ROWS;
        if (row_ok) begin
            for (v = 0; v < nv; v++) begin
                idx = v * N_ROWS + int'(row);
                if (column_store[idx] != 0) begin
                    found++;
                    sum += int'(column_store[idx]);
                end
            end
        end
        fill = found > 0 && found < nv;
        if (fill) mean = sum / found;
        for (v = 0; v < nv; v++) begin
            r.view   = VIEW_W'(v);
            r.row    = row;
            r.col    = '0;
            r.filled = 1'b0;
            r.last   = (v + 1 == nv);
            if (row_ok) begin
                idx   = v * N_ROWS + int'(row);
                r.col = column_store[idx];
                if (fill && r.col == 0) begin
                    r.col    = COL_W'(mean);
                    r.filled = 1'b1;
                end
                column_store[idx] = '0;
            end
            if (queue_it) queue_expected(r);
        end
    endfunction

    function automatic void push_typed_row(input t_scan_row s);
        int              v;
        t_profile_result r;
        for (v = 0; v < active_views(); v++) begin
            r.view   = VIEW_W'(v);
            r.row    = s.row;
            r.col    = s.typed_col;
            r.filled = s.typed_fill && (VIEW_W'(v) != s.typed_src);
            r.last   = (v + 1 == active_views());
            queue_expected(r);
        end
    endfunction

    // for a register write the column argument carries the view count
    function automatic void add_row(input t_action act, input int view, input int row,
                                    input int column, input int red, input bit typed = 0,
                                    input int tcol = 0, input bit tfill = 0,
                                    input int tsrc = 0);
        t_scan_row s;
        s.act        = act;
        s.view       = VIEW_W'(view);
        s.row        = ROW_W'(row);
        s.column     = COL_W'(column);
        s.red        = RED_W'(red);
        s.typed      = typed;
        s.typed_col  = COL_W'(tcol);
        s.typed_fill = tfill;
        s.typed_src  = VIEW_W'(tsrc);
        scan_table.insert(scan_table.size(), s);
    endfunction

    function automatic void note_mismatch(input string what, input t_profile_result e,
                                          input t_profile_result a);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s exp view %0d row %0d col %0d filled %0b last %0b",
                     $realtime, what, e.view, e.row, e.col, e.filled, e.last,
                     " / got view %0d row %0d col %0d filled %0b last %0b",
                     a.view, a.row, a.col, a.filled, a.last);
    endfunction

    task automatic send_scan_item(input t_action act, input logic [VIEW_W-1:0] view,
                                  input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                                  input logic [RED_W-1:0] red);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= (act == ACT_READ) ? REQ_ROW_READ : REQ_PIXEL;
        i_view      <= view;
        i_row       <= row;
        i_column    <= column;
        i_red_level <= red;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_views(input logic [NV_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_profile.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        views_reg = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1: begin
                send_idle_pct = 62;
                stall_pct     = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct     = 62;
            end
            default: begin
                send_idle_pct = 10;
                stall_pct     = 10;
            end
        endcase
    endtask

    // well-formed scans on a few rows, with stray views, dark pixels and empty reads
    task automatic run_phase(input logic [NV_W-1:0] nv, input int mode);
        logic [ROW_W-1:0]  pool [4];
        t_action           act;
        logic [VIEW_W-1:0] view;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [RED_W-1:0]  red;
        int                k;
        write_views(nv);
        set_idling(mode);
        for (k = 0; k < 4; k++) pool[k] = ROW_W'($urandom_range(0, N_ROWS - 1));
        for (k = 0; k < PHASE_ITEMS; k++) begin
            act  = ($urandom_range(0, 99) < 15) ? ACT_READ : ACT_PIXEL;
            row  = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, N_ROWS - 1))
                                               : pool[$urandom_range(0, 3)];
            view = ($urandom_range(0, 9) == 0) ? VIEW_W'($urandom_range(0, N_VIEWS - 1))
                                               : VIEW_W'($urandom_range(0, active_views() - 1));
            case ($urandom_range(0, 9))
                0:       col = '0;
                1:       col = COL_W'(N_COLS - 1);
                default: col = COL_W'($urandom);
            endcase
            red = ($urandom_range(0, 9) == 0) ? '0 : RED_W'($urandom);
            send_scan_item(act, view, row, col, red);
            if (act == ACT_READ) read_profile_row(row, 1'b1);
            else record_pixel(view, row, col, red);
        end
    endtask

    always @(posedge i_clk) begin
        t_profile_result a;
        t_profile_result e;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            a.view   = o_out_view;
            a.row    = o_out_row;
            a.col    = o_line_column;
            a.filled = o_was_filled;
            a.last   = o_last;
            if (expected_profile.size() == 0) begin
                e = '{default: '0};
                note_mismatch("unexpected transfer", e, a);
            end else begin
                e = expected_profile.pop_front();
                if (a.view !== e.view || a.row !== e.row || a.col !== e.col ||
                    a.filled !== e.filled || a.last !== e.last)
                    note_mismatch("profile mismatch", e, a);
            end
        end
        i_out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [NV_W-1:0] phase_views [10];
        t_scan_row       s;
        int              p;
        foreach (column_store[i]) column_store[i] = '0;
        views_reg = NV_RESET;
        phase_views = '{7'd64, 7'd1, 7'd5, 7'd0, 7'd33, 7'd127, 7'd2, 7'd65, 7'd17, 7'd64};

        // empty row after reset, single hit, dark pixel, column zero, clearing
        add_row(ACT_READ, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(ACT_PIXEL, 0, 5, 4095, 255);
        add_row(ACT_READ, 37, 5, 0, 0, 1, 4095, 1, 0);
        add_row(ACT_PIXEL, 63, 1023, 1, 1);
        add_row(ACT_PIXEL, 63, 1023, 0, 200);
        add_row(ACT_PIXEL, 10, 1023, 3000, 0);
        add_row(ACT_PIXEL, 10, 1023, 100, 128);
        add_row(ACT_PIXEL, 10, 1023, 50, 9);
        add_row(ACT_READ, 0, 1023, 0, 0);
        add_row(ACT_READ, 0, 1023, 0, 0, 1, 0, 0, 0);
        add_row(ACT_PIXEL, 0, 12, 0, 255);
        add_row(ACT_READ, 0, 12, 0, 0, 1, 0, 0, 0);
        // two views: all found, then one missing, stray view ignored
        add_row(ACT_CFG, 0, 0, 2, 0);
        add_row(ACT_PIXEL, 0, 7, 11, 5);
        add_row(ACT_PIXEL, 1, 7, 20, 5);
        add_row(ACT_READ, 0, 7, 0, 0);
        add_row(ACT_PIXEL, 0, 8, 11, 3);
        add_row(ACT_PIXEL, 63, 8, 500, 3);
        add_row(ACT_READ, 0, 8, 0, 0, 1, 11, 1, 0);
        // zero view count acts as one
        add_row(ACT_CFG, 0, 0, 0, 0);
        add_row(ACT_PIXEL, 1, 9, 77, 1);
        add_row(ACT_PIXEL, 0, 9, 4095, 255);
        add_row(ACT_READ, 0, 9, 0, 0, 1, 4095, 0, 0);
        // oversized view count acts as the maximum, truncated mean
        add_row(ACT_CFG, 0, 0, 127, 0);
        add_row(ACT_READ, 0, 8, 0, 0);
        add_row(ACT_PIXEL, 2, 3, 10, 40);
        add_row(ACT_PIXEL, 3, 3, 11, 40);
        add_row(ACT_PIXEL, 4, 3, 11, 40);
        add_row(ACT_READ, 0, 3, 0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (scan_table[i]) begin
            s = scan_table[i];
            if (s.act == ACT_CFG) begin
                write_views(NV_W'(s.column));
            end else begin
                send_scan_item(s.act, s.view, s.row, s.column, s.red);
                if (s.act == ACT_PIXEL) begin
                    record_pixel(s.view, s.row, s.column, s.red);
                end else if (s.typed) begin
                    read_profile_row(s.row, 1'b0);
                    push_typed_row(s);
                end else begin
                    read_profile_row(s.row, 1'b1);
                end
            end
        end

        for (p = 0; p < 10; p++) run_phase(phase_views[p], p % 4);

        i_in_valid <= 1'b0;
        while (expected_profile.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_profile.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lpgf_pkg.sv
sv/lpgf_div.sv
sv/laser_profile_gap_fill.sv
dv/tb_laser_profile_gap_fill.sv
